### src/flow_table_probe_engine_core_assert.svh
// Assertion macros for the flow table probe engine.
// Used by the back-end module; no other dependencies.
`ifndef FLOW_TABLE_PROBE_ENGINE_CORE_ASSERT_SVH
`define FLOW_TABLE_PROBE_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked out of reset only
`define FTPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset as well
`define FTPE_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTPE_ASSERT(lbl, prop, msg)
`define FTPE_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### src/ftpe_pkg.sv
// Shared types, constants and codes of the flow table probe engine.
// No dependencies.
`default_nettype none
package ftpe_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int PROBE_LIMIT   = 8;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int P_W   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    // operation codes
    localparam logic [1:0] FN_FLOW   = 2'd0;
    localparam logic [1:0] FN_REBASE = 2'd1;
    localparam logic [1:0] FN_FETCH  = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // result status codes
    localparam logic [2:0] RS_HIT      = 3'd0;
    localparam logic [2:0] RS_INSERTED = 3'd1;
    localparam logic [2:0] RS_OFF_DROP = 3'd2;
    localparam logic [2:0] RS_FULL     = 3'd3;
    localparam logic [2:0] RS_REBASED  = 3'd4;
    localparam logic [2:0] RS_UNSENT   = 3'd5;
    localparam logic [2:0] RS_NONE     = 3'd6;

    // slot states
    localparam logic [1:0] SL_EMPTY   = 2'd0;
    localparam logic [1:0] SL_SENT    = 2'd1;
    localparam logic [1:0] SL_UNSENT  = 2'd2;
    localparam logic [1:0] SL_DELETED = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_EXPIRY  = 3'd0;
    localparam logic [2:0] CFG_MAX_OFF = 3'd1;
    localparam logic [2:0] CFG_MIN_OFF = 3'd2;
    localparam logic [2:0] CFG_LIN     = 3'd3;
    localparam logic [2:0] CFG_SQ      = 3'd4;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] ports;
        logic [31:0] dip;
        logic [31:0] sip;
    } key_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] ts;
        key_t        key;
        logic [31:0] hash;
    } cmd_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [30:0] max_off;
        logic [31:0] min_off;
        logic [15:0] lin;
        logic [15:0] sq;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] idx;
        key_t             key;
        logic [31:0]      base;
        logic [CNT_W-1:0] live;
        logic [31:0]      expired;
        logic [31:0]      dropped;
    } res_t;
endpackage
`default_nettype wire

### src/ftpe_front.sv
// Front end: takes input beats and hashes the five-tuple byte by byte.
// Depends on ftpe_pkg.
`default_nettype none
module ftpe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    input  logic          in_valid,
    output logic          in_ready,
    input  ftpe_pkg::cmd_t in_cmd,
    output logic          q_push,
    output ftpe_pkg::cmd_t q_cmd,
    input  logic          q_full
);
    import ftpe_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [3:0] LAST_BYTE = 4'd12;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  bcnt_reg, bcnt_next;
    cmd_t        cmd_reg, cmd_next;
    logic [103:0] msg;
    logic [7:0]  byte_sel;

    // hashed byte order: sip, dip, src port, dst port (little-endian), protocol
    assign msg      = {cmd_reg.key.proto, cmd_reg.key.ports[15:8], cmd_reg.key.ports[7:0],
                       cmd_reg.key.ports[31:24], cmd_reg.key.ports[23:16],
                       cmd_reg.key.dip, cmd_reg.key.sip};
    assign byte_sel = msg[8*bcnt_reg +: 8];

    assign in_ready = enable && (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_cmd    = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        bcnt_next  = bcnt_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next      = in_cmd;
                    cmd_next.hash = FNV_BASIS;
                    bcnt_next     = '0;
                    state_next    = F_HASH;
                end
            end
            F_HASH:
            begin
                cmd_next.hash = (cmd_reg.hash ^ {24'd0, byte_sel}) * FNV_PRIME;
                bcnt_next     = bcnt_reg + 4'd1;
                if (bcnt_reg == LAST_BYTE)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            bcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

### src/ftpe_queue.sv
// Two-entry command queue between front and back end.
// Depends on ftpe_pkg.
`default_nettype none
module ftpe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ftpe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_vld,
    output ftpe_pkg::cmd_t head
);
    import ftpe_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign head_vld = (cnt_reg != 2'd0);
    assign head     = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_cmd;
    end
endmodule
`default_nettype wire

### src/ftpe_back.sv
// Back end: table memories and the probe / rebase / fetch sequencer.
// Depends on ftpe_pkg and flow_table_probe_engine_core_assert.svh.
`default_nettype none
`include "flow_table_probe_engine_core_assert.svh"
module ftpe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_vld,
    input  ftpe_pkg::cmd_t q_head,
    output logic          q_pop,
    input  ftpe_pkg::cfg_t cfg,
    output logic          init_done,
    output ftpe_pkg::res_t m_res,
    output logic          m_valid,
    input  logic          m_ready
);
    import ftpe_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_ADDR  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_INS   = 4'd5;
    localparam logic [3:0] S_RB    = 4'd6;
    localparam logic [3:0] S_FT    = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // table memories
    logic [1:0]  st_mem  [TABLE_ENTRIES];
    key_t        key_mem [TABLE_ENTRIES];
    logic [31:0] off_mem [TABLE_ENTRIES];
    logic [1:0]  st_q;
    key_t        key_q;
    logic [31:0] off_q;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic        st_we, key_we, off_we;
    logic [1:0]  st_wd;
    logic [31:0] off_wd;

    logic [3:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [31:0]      base_reg, base_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [31:0]      exp_reg, exp_next;
    logic [31:0]      drop_reg, drop_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             hf_reg, hf_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [IDX_W:0]   scan_reg, scan_next;
    logic             ev_reg, ev_next;
    logic [IDX_W-1:0] evi_reg, evi_next;
    logic [2:0]       rs_reg, rs_next;
    logic [IDX_W-1:0] ri_reg, ri_next;
    key_t             rk_reg, rk_next;
    logic [32:0]      shift_reg, shift_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    res_t             out_reg, out_next;
    logic             mv_reg, mv_next;

    // probe address
    logic [P_W+15:0]   lin_term;
    logic [2*P_W-1:0]  pp;
    logic [2*P_W+15:0] sq_term;
    logic [31:0]       probe_sum;
    logic signed [32:0] delta;
    logic signed [33:0] exp_sum;
    logic signed [33:0] rb_diff;
    logic              expired, live, match, scan_end;
    logic [1:0]        st_eff;
    logic              hf_t;
    logic [IDX_W-1:0]  free_t;

    assign pp        = {{P_W{1'b0}}, p_reg} * {{P_W{1'b0}}, p_reg};
    assign lin_term  = cfg.lin * p_reg;
    assign sq_term   = cfg.sq * pp;
    assign probe_sum = cmd_reg.hash + 32'(lin_term) + 32'(sq_term);

    assign delta   = $signed({1'b0, cmd_reg.ts}) - $signed({1'b0, base_reg});
    assign exp_sum = $signed({2'b00, base_reg}) + $signed({{2{off_q[31]}}, off_q})
                     + $signed({2'b00, cfg.expiry});
    assign rb_diff = $signed({{2{off_q[31]}}, off_q}) - $signed({shift_reg[32], shift_reg});
    assign expired = (st_q == SL_SENT) && (exp_sum < $signed({2'b00, cmd_reg.ts}));
    assign st_eff  = expired ? SL_DELETED : st_q;
    assign live    = (st_eff == SL_SENT) || (st_eff == SL_UNSENT);
    assign match   = (key_q == cmd_reg.key);
    assign scan_end = (scan_reg == (IDX_W+1)'(TABLE_ENTRIES));

    assign init_done = (state_reg != S_CLEAR);
    assign m_res     = out_reg;
    assign m_valid   = mv_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        base_next  = base_reg;
        occ_next   = occ_reg;
        exp_next   = exp_reg;
        drop_next  = drop_reg;
        p_next     = p_reg;
        cur_next   = cur_reg;
        hf_next    = hf_reg;
        free_next  = free_reg;
        scan_next  = scan_reg;
        ev_next    = 1'b0;
        evi_next   = evi_reg;
        rs_next    = rs_reg;
        ri_next    = ri_reg;
        rk_next    = rk_reg;
        shift_next = shift_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;
        q_pop      = 1'b0;
        rd_addr    = scan_reg[IDX_W-1:0];
        wr_addr    = cur_reg;
        st_we      = 1'b0;
        key_we     = 1'b0;
        off_we     = 1'b0;
        st_wd      = SL_EMPTY;
        off_wd     = cmd_reg.ts - base_reg;
        hf_t       = hf_reg;
        free_t     = free_reg;
        unique case (state_reg)
            // clearing pass over the slot status memory
            S_CLEAR:
            begin
                st_we    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {IDX_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_vld)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    ri_next    = '0;
                    rk_next    = '0;
                    scan_next  = '0;
                    shift_next = $signed({1'b0, q_head.ts}) - $signed({1'b0, base_reg});
                    unique case (q_head.func)
                        FN_FLOW:   state_next = S_CHECK;
                        FN_REBASE: state_next = S_RB;
                        FN_FETCH:  state_next = S_FT;
                        default:
                        begin
                            rs_next    = RS_NONE;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // time offset window check
            S_CHECK:
            begin
                if ((occ_reg != '0) &&
                    ((delta > $signed({2'b00, cfg.max_off})) ||
                     (delta < $signed({cfg.min_off[31], cfg.min_off}))))
                begin
                    drop_next  = drop_reg + 32'd1;
                    rs_next    = RS_OFF_DROP;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = '0;
                    hf_next    = 1'b0;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                rd_addr    = probe_sum[IDX_W-1:0];
                cur_next   = probe_sum[IDX_W-1:0];
                state_next = S_EVAL;
            end
            // one probe: expire, match, free slot tracking
            S_EVAL:
            begin
                if (expired)
                begin
                    st_we    = 1'b1;
                    st_wd    = SL_DELETED;
                    occ_next = occ_reg - 1'b1;
                    exp_next = exp_reg + 32'd1;
                end
                if (live && match)
                begin
                    off_we     = 1'b1;
                    rs_next    = RS_HIT;
                    ri_next    = cur_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!live && !hf_reg)
                    begin
                        hf_t   = 1'b1;
                        free_t = cur_reg;
                    end
                    hf_next   = hf_t;
                    free_next = free_t;
                    if ((!live && (st_eff == SL_EMPTY)) || (p_reg == P_W'(PROBE_LIMIT - 1)))
                    begin
                        if (hf_t)
                            state_next = S_INS;
                        else
                        begin
                            drop_next  = drop_reg + 32'd1;
                            rs_next    = RS_FULL;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_ADDR;
                    end
                end
            end
            S_INS:
            begin
                wr_addr = free_reg;
                st_we   = 1'b1;
                key_we  = 1'b1;
                off_we  = 1'b1;
                st_wd   = SL_UNSENT;
                if (occ_reg == '0)
                begin
                    base_next = cmd_reg.ts;
                    off_wd    = '0;
                end
                occ_next   = occ_reg + 1'b1;
                rs_next    = RS_INSERTED;
                ri_next    = free_reg;
                state_next = S_DONE;
            end
            // rebase sweep, read one entry per cycle, evaluate one behind
            S_RB:
            begin
                if (!scan_end)
                begin
                    scan_next = scan_reg + 1'b1;
                    ev_next   = 1'b1;
                    evi_next  = scan_reg[IDX_W-1:0];
                end
                if (ev_reg && ((st_q == SL_SENT) || (st_q == SL_UNSENT)))
                begin
                    wr_addr = evi_reg;
                    if (rb_diff < $signed({{2{cfg.min_off[31]}}, cfg.min_off}))
                    begin
                        st_we    = 1'b1;
                        st_wd    = SL_DELETED;
                        occ_next = occ_reg - 1'b1;
                    end
                    else
                    begin
                        off_we = 1'b1;
                        off_wd = off_q - shift_reg[31:0];
                    end
                end
                if (scan_end && !ev_reg)
                begin
                    base_next  = cmd_reg.ts;
                    rs_next    = RS_REBASED;
                    state_next = S_DONE;
                end
            end
            // fetch sweep for the lowest unsent slot
            S_FT:
            begin
                if (!scan_end)
                begin
                    scan_next = scan_reg + 1'b1;
                    ev_next   = 1'b1;
                    evi_next  = scan_reg[IDX_W-1:0];
                end
                if (ev_reg && (st_q == SL_UNSENT))
                begin
                    wr_addr    = evi_reg;
                    st_we      = 1'b1;
                    st_wd      = SL_SENT;
                    rs_next    = RS_UNSENT;
                    ri_next    = evi_reg;
                    rk_next    = key_q;
                    ev_next    = 1'b0;
                    state_next = S_DONE;
                end
                else if (scan_end && !ev_reg)
                begin
                    rs_next    = RS_NONE;
                    state_next = S_DONE;
                end
            end
            // load the output register once it is free
            S_DONE:
            begin
                if (!mv_reg || m_ready)
                begin
                    out_next.status  = rs_reg;
                    out_next.idx     = ri_reg;
                    out_next.key     = rk_reg;
                    out_next.base    = base_reg;
                    out_next.live    = occ_reg;
                    out_next.expired = exp_reg;
                    out_next.dropped = drop_reg;
                    mv_next          = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            base_reg  <= '0;
            occ_reg   <= '0;
            exp_reg   <= '0;
            drop_reg  <= '0;
            ev_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            base_reg  <= base_next;
            occ_reg   <= occ_next;
            exp_reg   <= exp_next;
            drop_reg  <= drop_next;
            ev_reg    <= ev_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        p_reg     <= p_next;
        cur_reg   <= cur_next;
        hf_reg    <= hf_next;
        free_reg  <= free_next;
        scan_reg  <= scan_next;
        evi_reg   <= evi_next;
        rs_reg    <= rs_next;
        ri_reg    <= ri_next;
        rk_reg    <= rk_next;
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

    // memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[wr_addr] <= st_wd;
        if (key_we)
            key_mem[wr_addr] <= cmd_reg.key;
        if (off_we)
            off_mem[wr_addr] <= off_wd;
        st_q  <= st_mem[rd_addr];
        key_q <= key_mem[rd_addr];
        off_q <= off_mem[rd_addr];
    end

    `FTPE_ASSERT(a_occ_bound, occ_reg <= CNT_W'(TABLE_ENTRIES), "live count above table size")
    `FTPE_ASSERT(a_no_pop_clear, (state_reg == S_CLEAR) |-> !q_pop, "command taken during clear")
    `FTPE_ASSERT(a_done_wait, (state_reg == S_DONE && mv_reg && !m_ready) |=> (state_reg == S_DONE), "result overwrote pending beat")
    `FTPE_ASSERT_NR(a_rst_state, !rst_n |-> (state_reg == S_CLEAR && !mv_reg), "reset did not restart clear")
endmodule
`default_nettype wire

### src/flow_table_probe_engine_core.sv
// Flow table probe engine: hash of the 13 key bytes, then up to 8 probes (address, evaluate) plus insert;
// rebase and fetch sweep the 1024-entry table at one entry a cycle.
// The front takes a new beat only once it has hashed and queued the previous one.
// After reset a clearing pass over all 1024 slot status entries runs; s_tready stays low.
// Config writes are taken at any time; results wait in an output register.
// Top level: configuration registers, front, queue, back. Depends on ftpe_pkg.
`default_nettype none
module flow_table_probe_engine_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp, src_ip, dst_ip, protocol, src_port, dst_port
    input  logic [135:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_index, out_src_ip, out_dst_ip, out_protocol, out_src_port, out_dst_port,
    // base_time, live_count, expired_total, dropped_total, zero fill
    output logic [223:0] m_tdata,
    // status
    output logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ftpe_pkg::*;

    cfg_t cfg_reg;
    cmd_t in_cmd, f_cmd, q_head;
    logic f_push, q_full, q_vld, q_pop, init_done;
    res_t res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expiry  <= 32'd3600;
            cfg_reg.max_off <= 31'h7FFFFFFF;
            cfg_reg.min_off <= 32'h80000000;
            cfg_reg.lin     <= 16'd1;
            cfg_reg.sq      <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPIRY:  cfg_reg.expiry  <= cfg_data;
                CFG_MAX_OFF: cfg_reg.max_off <= cfg_data[30:0];
                CFG_MIN_OFF: cfg_reg.min_off <= cfg_data;
                CFG_LIN:     cfg_reg.lin     <= cfg_data[15:0];
                CFG_SQ:      cfg_reg.sq      <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // unpack input beat
    always_comb
    begin
        in_cmd.func      = s_tuser;
        in_cmd.ts        = s_tdata[31:0];
        in_cmd.key.sip   = s_tdata[63:32];
        in_cmd.key.dip   = s_tdata[95:64];
        in_cmd.key.proto = s_tdata[103:96];
        in_cmd.key.ports = {s_tdata[119:104], s_tdata[135:120]};
        in_cmd.hash      = '0;
    end

    ftpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (init_done),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (in_cmd),
        .q_push   (f_push),
        .q_cmd    (f_cmd),
        .q_full   (q_full)
    );

    ftpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_vld (q_vld),
        .head     (q_head)
    );

    ftpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_vld     (q_vld),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .init_done (init_done),
        .m_res     (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready)
    );

    // pack result beat
    assign m_tuser = res.status;
    assign m_tdata = {3'd0, res.dropped, res.expired, res.live, res.base,
                      res.key.ports[15:0], res.key.ports[31:16], res.key.proto,
                      res.key.dip, res.key.sip, res.idx};
endmodule
`default_nettype wire

### bench/flow_table_probe_engine_core_test.sv
// Self-checking bench for the flow table probe engine: random flow, rebase and fetch beats
// with random idling on both streams, checked beat by beat against an in-bench flow cache.
// Depends on ftpe_pkg and flow_table_probe_engine_core.
`timescale 1ns / 100ps
`default_nettype none
module flow_table_probe_engine_core_test;
    import ftpe_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] ts;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [7:0]  proto;
        logic [15:0] sp;
        logic [15:0] dp;
    } flow_cmd_t;

    typedef struct {
        logic [2:0]       status;
        logic [IDX_W-1:0] idx;
        logic [31:0]      sip;
        logic [31:0]      dip;
        logic [7:0]       proto;
        logic [15:0]      sp;
        logic [15:0]      dp;
        logic [31:0]      base;
        logic [CNT_W-1:0] live;
        logic [31:0]      expired;
        logic [31:0]      dropped;
    } flow_res_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    flow_table_probe_engine_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // cache shadow state
    logic [31:0] tbl_sip [TABLE_ENTRIES];
    logic [31:0] tbl_dip [TABLE_ENTRIES];
    logic [31:0] tbl_ports [TABLE_ENTRIES];
    logic [7:0]  tbl_proto [TABLE_ENTRIES];
    logic [1:0]  tbl_state [TABLE_ENTRIES];
    logic [31:0] tbl_off [TABLE_ENTRIES];
    logic [31:0] base_sec = '0;
    int          live_cnt = 0;
    logic [31:0] expired_cnt = '0;
    logic [31:0] dropped_cnt = '0;

    // shadow configuration
    logic [31:0] expiry_sec = 32'd3600;
    logic [30:0] max_off = 31'h7FFFFFFF;
    logic [31:0] min_off = 32'h80000000;
    logic [15:0] lin_coeff = 16'd1;
    logic [15:0] sq_coeff = 16'd1;

    flow_cmd_t pending_beats[$];
    flow_res_t expected_results[$];
    flow_cmd_t cur_beat;
    int        fail_count = 0;
    int        s_gap = 0;
    int        m_stall = 0;
    bit        no_idle = 1'b0;

    function automatic logic [31:0] fnv_hash(flow_cmd_t c);
        logic [31:0]  h;
        logic [103:0] bytes;
        h = FNV_BASIS;
        bytes = {c.proto, c.dp, c.sp, c.dip, c.sip};
        for (int i = 0; i < 13; i++)
            h = (h ^ {24'd0, bytes[8*i +: 8]}) * FNV_PRIME;
        return h;
    endfunction

    function automatic bit slot_live(int i);
        return tbl_state[i] == SL_SENT || tbl_state[i] == SL_UNSENT;
    endfunction

    // flow update: probe, expire, match or insert
    function automatic logic [2:0] update_flow(flow_cmd_t c, output logic [IDX_W-1:0] idx);
        logic [31:0] h;
        logic [31:0] ports;
        logic [31:0] pos;
        longint      delta;
        bit          have_free;
        int          free_slot;
        int          s;
        h = fnv_hash(c);
        ports = {c.sp, c.dp};
        delta = longint'(c.ts) - longint'(base_sec);
        have_free = 1'b0;
        free_slot = 0;
        idx = '0;
        if (live_cnt > 0 && (delta > longint'(max_off) ||
                             delta < longint'($signed(min_off))))
        begin
            dropped_cnt++;
            return RS_OFF_DROP;
        end
        for (int p = 0; p < PROBE_LIMIT; p++)
        begin
            pos = h + 32'(lin_coeff) * p + 32'(sq_coeff) * p * p;
            s = pos % TABLE_ENTRIES;
            if (tbl_state[s] == SL_SENT && longint'(base_sec) + longint'($signed(tbl_off[s]))
                    + longint'(expiry_sec) < longint'(c.ts))
            begin
                tbl_state[s] = SL_DELETED;
                live_cnt--;
                expired_cnt++;
            end
            if (slot_live(s) && tbl_sip[s] == c.sip && tbl_dip[s] == c.dip &&
                tbl_proto[s] == c.proto && tbl_ports[s] == ports)
            begin
                tbl_off[s] = c.ts - base_sec;
                idx = IDX_W'(s);
                return RS_HIT;
            end
            if (!slot_live(s))
            begin
                if (!have_free)
                begin
                    have_free = 1'b1;
                    free_slot = s;
                end
                if (tbl_state[s] == SL_EMPTY) break;
            end
        end
        if (!have_free)
        begin
            dropped_cnt++;
            return RS_FULL;
        end
        if (live_cnt == 0) base_sec = c.ts;
        tbl_sip[free_slot] = c.sip;
        tbl_dip[free_slot] = c.dip;
        tbl_ports[free_slot] = ports;
        tbl_proto[free_slot] = c.proto;
        tbl_state[free_slot] = SL_UNSENT;
        tbl_off[free_slot] = c.ts - base_sec;
        live_cnt++;
        idx = IDX_W'(free_slot);
        return RS_INSERTED;
    endfunction

    function automatic flow_res_t predict_result(flow_cmd_t c);
        flow_res_t r;
        longint    shift;
        r = '{status: RS_NONE, default: '0};
        if (c.func == FN_FLOW)
        begin
            r.status = update_flow(c, r.idx);
        end
        else if (c.func == FN_REBASE)
        begin
            shift = longint'(c.ts) - longint'(base_sec);
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!slot_live(i)) continue;
                if (longint'($signed(tbl_off[i])) - shift < longint'($signed(min_off)))
                begin
                    tbl_state[i] = SL_DELETED;
                    live_cnt--;
                end
                else
                begin
                    tbl_off[i] = tbl_off[i] - (c.ts - base_sec);
                end
            end
            base_sec = c.ts;
            r.status = RS_REBASED;
        end
        else if (c.func == FN_FETCH)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tbl_state[i] == SL_UNSENT)
                begin
                    tbl_state[i] = SL_SENT;
                    r.status = RS_UNSENT;
                    r.idx = IDX_W'(i);
                    r.sip = tbl_sip[i];
                    r.dip = tbl_dip[i];
                    r.proto = tbl_proto[i];
                    r.sp = tbl_ports[i][31:16];
                    r.dp = tbl_ports[i][15:0];
                    break;
                end
            end
        end
        r.base = base_sec;
        r.live = CNT_W'(live_cnt);
        r.expired = expired_cnt;
        r.dropped = dropped_cnt;
        return r;
    endfunction

    // input driver: predicts each accepted beat, then loads the next after a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(cur_beat));
            if (!s_tvalid || s_tready)
            begin
                if (s_gap > 0)
                begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_beat.func;
                    s_tdata <= {cur_beat.dp, cur_beat.sp, cur_beat.proto,
                                cur_beat.dip, cur_beat.sip, cur_beat.ts};
                    s_gap <= no_idle ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        flow_res_t e;
        int        n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_stall <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("status", e.status, m_tuser);
                check_field("entry_index", e.idx, m_tdata[9:0]);
                check_field("out_src_ip", e.sip, m_tdata[41:10]);
                check_field("out_dst_ip", e.dip, m_tdata[73:42]);
                check_field("out_protocol", e.proto, m_tdata[81:74]);
                check_field("out_src_port", e.sp, m_tdata[97:82]);
                check_field("out_dst_port", e.dp, m_tdata[113:98]);
                check_field("base_time", e.base, m_tdata[145:114]);
                check_field("live_count", e.live, m_tdata[156:146]);
                check_field("expired_total", e.expired, m_tdata[188:157]);
                check_field("dropped_total", e.dropped, m_tdata[220:189]);
            end
            n = no_idle ? 0 : $urandom_range(0, 7);
            m_stall <= n;
            m_tready <= (n == 0);
        end
        else if (m_stall > 0)
        begin
            m_stall <= m_stall - 1;
            m_tready <= (m_stall == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // flow key pool so that hits and collisions happen
    logic [31:0] pool_sip [64];
    logic [31:0] pool_dip [64];
    logic [31:0] pool_ports [64];
    logic [7:0]  pool_proto [64];
    logic [31:0] now_sec;

    function automatic flow_cmd_t make_beat(logic [1:0] f, logic [31:0] ts, int k);
        flow_cmd_t c;
        c.func = f;
        c.ts = ts;
        c.sip = pool_sip[k];
        c.dip = pool_dip[k];
        c.proto = pool_proto[k];
        c.sp = pool_ports[k][31:16];
        c.dp = pool_ports[k][15:0];
        return c;
    endfunction

    task automatic wait_idle();
        wait (pending_beats.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_EXPIRY:  expiry_sec = value;
            CFG_MAX_OFF: max_off = value[30:0];
            CFG_MIN_OFF: min_off = value;
            CFG_LIN:     lin_coeff = value[15:0];
            CFG_SQ:      sq_coeff = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int        sel;
        int        k;
        flow_cmd_t c;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            k = $urandom_range(0, 63);
            now_sec = now_sec + $urandom_range(0, 40);
            if (sel < 70)
            begin
                c = make_beat(FN_FLOW, now_sec + $urandom_range(0, 20), k);
            end
            else if (sel < 78)
            begin
                // wild key and time, mostly offset drops
                c = make_beat(FN_FLOW, $urandom, k);
                c.sip = $urandom;
                c.dip = $urandom;
                c.proto = $urandom;
                c.sp = $urandom;
                c.dp = $urandom;
            end
            else if (sel < 92)
            begin
                c = make_beat(FN_FETCH, $urandom, k);
            end
            else if (sel < 96)
            begin
                now_sec = now_sec + $urandom_range(0, 3000);
                c = make_beat(FN_REBASE, now_sec, k);
            end
            else
            begin
                c = make_beat(FN_UNUSED, $urandom, k);
            end
            pending_beats.push_back(c);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_state[i] = SL_EMPTY;
        for (int i = 0; i < 64; i++)
        begin
            pool_sip[i] = $urandom;
            pool_dip[i] = $urandom;
            pool_ports[i] = $urandom;
            pool_proto[i] = $urandom;
        end
        pool_sip[0] = '0; pool_dip[0] = '0; pool_ports[0] = '0; pool_proto[0] = '0;
        pool_sip[1] = '1; pool_dip[1] = '1; pool_ports[1] = '1; pool_proto[1] = '1;
        now_sec = 32'd100000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty fetch, insert, hit, extreme keys and times, rebase, unused code
        pending_beats.push_back(make_beat(FN_FETCH, 0, 0));
        pending_beats.push_back(make_beat(FN_FLOW, now_sec, 0));
        pending_beats.push_back(make_beat(FN_FLOW, now_sec + 5, 0));
        pending_beats.push_back(make_beat(FN_FLOW, now_sec + 6, 1));
        pending_beats.push_back(make_beat(FN_FLOW, 32'd0, 2));
        pending_beats.push_back(make_beat(FN_FLOW, 32'hFFFFFFFF, 3));
        pending_beats.push_back(make_beat(FN_FETCH, 0, 0));
        pending_beats.push_back(make_beat(FN_FLOW, now_sec + 5000, 0));
        pending_beats.push_back(make_beat(FN_FETCH, 0, 0));
        pending_beats.push_back(make_beat(FN_FETCH, 0, 0));
        pending_beats.push_back(make_beat(FN_UNUSED, 32'hFFFFFFFF, 1));
        pending_beats.push_back(make_beat(FN_REBASE, now_sec + 10, 0));
        pending_beats.push_back(make_beat(FN_FLOW, now_sec + 12, 4));
        pending_beats.push_back(make_beat(FN_REBASE, 32'hFFFFFFFF, 0));
        pending_beats.push_back(make_beat(FN_REBASE, 32'd0, 0));
        pending_beats.push_back(make_beat(FN_FLOW, 32'hFFFFFFFF, 5));
        pending_beats.push_back(make_beat(FN_FLOW, 32'd0, 5));
        pending_beats.push_back(make_beat(FN_FETCH, 0, 0));
        random_phase(380);
        wait_idle();

        // short expiry, narrow window: expiries and offset drops
        write_cfg(CFG_EXPIRY, 32'd0);
        write_cfg(CFG_MAX_OFF, 32'd1000);
        write_cfg(CFG_MIN_OFF, -32'sd1000);
        write_cfg(CFG_LIN, 32'd1);
        write_cfg(CFG_SQ, 32'd1);
        random_phase(380);
        wait_idle();

        // every probe on the home slot: full drops; min offset zero
        write_cfg(CFG_EXPIRY, 32'hFFFFFFFF);
        write_cfg(CFG_MAX_OFF, 32'h7FFFFFFF);
        write_cfg(CFG_MIN_OFF, 32'd0);
        write_cfg(CFG_LIN, 32'd0);
        write_cfg(CFG_SQ, 32'd0);
        random_phase(380);
        wait_idle();

        // largest coefficients, zero max offset
        write_cfg(CFG_EXPIRY, 32'd30);
        write_cfg(CFG_MAX_OFF, 32'd0);
        write_cfg(CFG_MIN_OFF, 32'h80000000);
        write_cfg(CFG_LIN, 32'hFFFF);
        write_cfg(CFG_SQ, 32'hFFFF);
        random_phase(380);
        wait_idle();

        // random coefficients, moderate window
        write_cfg(CFG_EXPIRY, 32'd3600);
        write_cfg(CFG_MAX_OFF, 32'd5000);
        write_cfg(CFG_MIN_OFF, -32'sd5000);
        write_cfg(CFG_LIN, $urandom_range(0, 65535));
        write_cfg(CFG_SQ, $urandom_range(0, 65535));
        random_phase(420);
        wait_idle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
